// ===== rtl/scf_pkg.sv =====
// package for the serial command frame parser
// holds the phase and role codes and the frame letter constants; no dependencies
package scf_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned RoleW  = 3;
    localparam int unsigned IndexW = 7;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_TYPE = 3'd1,
        PH_SUB  = 3'd2,
        PH_LEN  = 3'd3,
        PH_PAY  = 3'd4
    } t_phase;

    typedef enum logic [RoleW-1:0] {
        ROLE_IGN   = 3'd0,
        ROLE_START = 3'd1,
        ROLE_TYPE  = 3'd2,
        ROLE_SUB   = 3'd3,
        ROLE_LEN   = 3'd4,
        ROLE_PAY   = 3'd5
    } t_role;

    localparam logic [ByteW-1:0] CH_M = 8'h4D;
    localparam logic [ByteW-1:0] CH_I = 8'h49;
    localparam logic [ByteW-1:0] CH_C = 8'h43;
    localparam logic [ByteW-1:0] CH_T = 8'h54;
    localparam logic [ByteW-1:0] CH_R = 8'h52;
    localparam logic [ByteW-1:0] CH_V = 8'h56;
    localparam logic [ByteW-1:0] CH_O = 8'h4F;
    localparam logic [ByteW-1:0] CH_X = 8'h58;
    localparam logic [ByteW-1:0] CH_N = 8'h4E;
    localparam logic [ByteW-1:0] CH_P = 8'h50;
    localparam logic [ByteW-1:0] CH_S = 8'h53;
    localparam logic [ByteW-1:0] CH_F = 8'h46;

endpackage

// ===== rtl/serial_command_frame_parser_top.sv =====
// serial command frame parser: tags each received byte with its role in a frame
// depends on scf_pkg for phase and role codes and frame letters
//
// usage:
//   input channel: i_valid / o_stall carry one received word (i_rx_byte) per
//   accepted handshake. output channel: o_valid / i_stall carry one tagged word
//   per input word: the byte itself, its role, the frame type letter, the
//   payload position and the done / error flags.
//   a word's result is registered and shows on the output in the cycle after
//   it is accepted. one word per cycle while the receiver does not stall, set
//   by the single output register that parse state and result are written into.
//   a new word is taken whenever the output register is empty or its word is
//   being taken in the same cycle, so o_stall rises only while the receiver
//   stalls a held result; the held result stays unchanged while stalled.
//   reset (i_rst_n low, synchronous) returns the parser to hunting for the
//   start byte and empties the output register.
module serial_command_frame_parser_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [scf_pkg::ByteW-1:0]   i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [scf_pkg::ByteW-1:0]   o_byte_out,
    output logic [scf_pkg::RoleW-1:0]   o_role,
    output logic [scf_pkg::ByteW-1:0]   o_frame_type,
    output logic [scf_pkg::IndexW-1:0]  o_payload_index,
    output logic                        o_frame_done,
    output logic                        o_frame_error
);
    import scf_pkg::*;

    t_phase              r_phase, n_phase;
    logic [ByteW-1:0]    r_type_letter, n_type_letter;
    logic [IndexW-1:0]   r_bytes_left, n_bytes_left;
    logic [IndexW-1:0]   r_payload_pos, n_payload_pos;

    logic                r_valid;
    logic [ByteW-1:0]    r_byte;
    t_role               r_role, n_role;
    logic [ByteW-1:0]    r_ftype, n_ftype;
    logic [IndexW-1:0]   r_pidx, n_pidx;
    logic                r_done, n_done;
    logic                r_err, n_err;

    logic                accept;
    logic [ByteW-1:0]    b;

    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign b       = i_rx_byte;

    always_comb begin
        n_phase       = r_phase;
        n_type_letter = r_type_letter;
        n_bytes_left  = r_bytes_left;
        n_payload_pos = r_payload_pos;
        n_role        = ROLE_IGN;
        n_ftype       = '0;
        n_pidx        = '0;
        n_done        = 1'b0;
        n_err         = 1'b0;

        case (r_phase)
            PH_TYPE: begin
                n_role  = ROLE_TYPE;
                n_ftype = b;
                if (b == CH_I || b == CH_C || b == CH_T || b == CH_R) begin
                    n_done        = 1'b1;
                    n_phase       = PH_HUNT;
                    n_type_letter = '0;
                    n_bytes_left  = '0;
                    n_payload_pos = '0;
                end else if (b == CH_V) begin
                    n_type_letter = b;
                    n_phase       = PH_SUB;
                end else if (b == CH_N || b == CH_P || b == CH_S || b == CH_F) begin
                    n_type_letter = b;
                    n_phase       = PH_LEN;
                end else begin
                    n_err         = 1'b1;
                    n_phase       = PH_HUNT;
                    n_type_letter = '0;
                    n_bytes_left  = '0;
                    n_payload_pos = '0;
                end
            end
            PH_SUB: begin
                n_role  = ROLE_SUB;
                n_ftype = r_type_letter;
                if (b == CH_O || b == CH_I || b == CH_X) begin
                    n_done = 1'b1;
                end else begin
                    n_err = 1'b1;
                end
                n_phase       = PH_HUNT;
                n_type_letter = '0;
                n_bytes_left  = '0;
                n_payload_pos = '0;
            end
            PH_LEN: begin
                n_role  = ROLE_LEN;
                n_ftype = r_type_letter;
                // length is a signed byte: only 1..127 carries a payload
                if (!b[ByteW-1] && (b[IndexW-1:0] != '0)) begin
                    n_bytes_left  = b[IndexW-1:0];
                    n_payload_pos = '0;
                    n_phase       = PH_PAY;
                end else begin
                    n_done        = 1'b1;
                    n_phase       = PH_HUNT;
                    n_type_letter = '0;
                    n_bytes_left  = '0;
                    n_payload_pos = '0;
                end
            end
            PH_PAY: begin
                n_role  = ROLE_PAY;
                n_ftype = r_type_letter;
                n_pidx  = r_payload_pos;
                if (r_bytes_left <= IndexW'(1)) begin
                    n_done        = 1'b1;
                    n_phase       = PH_HUNT;
                    n_type_letter = '0;
                    n_bytes_left  = '0;
                    n_payload_pos = '0;
                end else begin
                    n_bytes_left  = r_bytes_left - IndexW'(1);
                    n_payload_pos = r_payload_pos + IndexW'(1);
                end
            end
            default: begin
                // hunting, and any unused phase code
                n_phase       = PH_HUNT;
                n_type_letter = '0;
                n_bytes_left  = '0;
                n_payload_pos = '0;
                if (b == CH_M) begin
                    n_role  = ROLE_START;
                    n_phase = PH_TYPE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_type_letter <= '0;
            r_bytes_left  <= '0;
            r_payload_pos <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_type_letter <= n_type_letter;
                r_bytes_left  <= n_bytes_left;
                r_payload_pos <= n_payload_pos;
                r_valid       <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte  <= b;
            r_role  <= n_role;
            r_ftype <= n_ftype;
            r_pidx  <= n_pidx;
            r_done  <= n_done;
            r_err   <= n_err;
        end
    end

    assign o_valid         = r_valid;
    assign o_byte_out      = r_byte;
    assign o_role          = r_role;
    assign o_frame_type    = r_ftype;
    assign o_payload_index = r_pidx;
    assign o_frame_done    = r_done;
    assign o_frame_error   = r_err;

endmodule
